[hdl/rmu_pkg.sv]
`timescale 1ns / 1ps
// Shared constants and types for the running median unit.
// Depends on nothing; used by every module of the block.
package rmu_pkg;

	// Number of samples the sorted chain can hold.
	localparam int CAPACITY = 64;
	// Width of one stored sample.
	localparam int DATA_WIDTH = 32;
	// Widths of the external sample and result fields.
	localparam int SAMPLE_WIDTH = 32;
	localparam int COUNT_PORT_WIDTH = 7;

	// A count runs from zero up to CAPACITY; an index stays below it.
	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam int IDX_W = $clog2(CAPACITY);

	typedef logic signed [DATA_WIDTH-1:0] data_t;
	typedef logic [CNT_W-1:0] count_t;
	typedef logic [IDX_W-1:0] index_t;

	// Per-stage control that the top level hands to each storage stage.
	typedef struct packed {
		logic ins;    // an insertion takes place in this cycle
		logic occ;    // this stage holds a sample of the current sequence
		logic at_end; // this stage is the first free place
	} stage_ctl_t;

endpackage

[hdl/rmu_cell.sv]
`timescale 1ns / 1ps
// One stage of the sorted insertion chain: holds one sample.
// Depends on rmu_pkg for the data type and the control struct.
module rmu_cell (
	input  logic                clk,
	input  rmu_pkg::stage_ctl_t ctl,
	input  rmu_pkg::data_t      new_val,
	input  rmu_pkg::data_t      prev_val,
	input  logic                prev_gt,
	output rmu_pkg::data_t      val,
	output logic                gt
);

	rmu_pkg::data_t val_q;

	// This stage holds a sample greater than the incoming one.
	assign gt = ctl.occ && (val_q > new_val);
	assign val = val_q;

	// Shift the lower neighbor up, or take the new sample at its sorted place.
	always_ff @(posedge clk) begin
		if (ctl.ins) begin
			if (prev_gt) begin
				val_q <= prev_val;
			end else if (gt || ctl.at_end) begin
				val_q <= new_val;
			end
		end
	end

endmodule

[hdl/running_median_unit.sv]
`timescale 1ns / 1ps
// Top level of the running median unit: insertion chain, count and result stage.
// Depends on rmu_pkg and rmu_cell.
//
// The unit keeps every sample of the current sequence in a chain of CAPACITY
// storage stages held in ascending order. A transaction with start_req set
// begins a new sequence. Each accepted sample is placed into the chain at the
// clock edge that accepts it: every stage compares its sample with the new one
// in parallel and either keeps its value, takes its lower neighbor's value or
// takes the new sample. The median stage then picks the lower median from the
// chain by an AND-OR select and writes it to the output register, which
// presents it, once that register is free. One sample can be accepted in
// every cycle, so the sustained rate is one transaction per cycle while the
// output side does not stall. The input stalls only while a result waits in
// the median stage and the output register holds a result that the output
// side is stalling. When the store already holds CAPACITY samples and
// start_req is low, the sample is dropped and full_res is set.
module running_median_unit (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   in_valid,
	output logic                                   in_stall,
	input  logic signed [rmu_pkg::SAMPLE_WIDTH-1:0] sample,
	input  logic                                   start_req,
	output logic                                   out_valid,
	input  logic                                   out_stall,
	output logic signed [rmu_pkg::SAMPLE_WIDTH-1:0] median,
	output logic [rmu_pkg::COUNT_PORT_WIDTH-1:0]    stored_count,
	output logic                                   full_res
);

	localparam int CAP = rmu_pkg::CAPACITY;

	rmu_pkg::count_t     count_q;
	logic                valid_s1;
	logic                full_s1;
	logic                out_valid_q;
	logic signed [rmu_pkg::SAMPLE_WIDTH-1:0] median_q;
	logic [rmu_pkg::COUNT_PORT_WIDTH-1:0]    count_out_q;
	logic                full_q;

	logic                in_take;
	logic                s1_adv;
	logic                drop;
	rmu_pkg::count_t     eff_count;
	rmu_pkg::data_t      new_val;
	rmu_pkg::index_t     med_idx;
	rmu_pkg::data_t      med_val;

	rmu_pkg::stage_ctl_t ctl_w      [CAP];
	rmu_pkg::data_t      val_w      [CAP];
	rmu_pkg::data_t      prev_val_w [CAP];
	logic                gt_w       [CAP];
	logic                prev_gt_w  [CAP];

	// Handshake: the result stage drains when the output register is free.
	assign s1_adv   = !out_valid_q || !out_stall;
	assign in_stall = valid_s1 && !s1_adv;
	assign in_take  = in_valid && !in_stall;

	// A start empties the store; a full store without start drops the sample.
	assign eff_count = start_req ? '0 : count_q;
	assign drop      = !start_req && (count_q == rmu_pkg::count_t'(CAP));
	assign new_val   = rmu_pkg::DATA_WIDTH'(sample);

	// Per-stage control and neighbor links.
	always_comb begin
		for (int i = 0; i < CAP; i++) begin
			ctl_w[i].ins    = in_take && !drop;
			ctl_w[i].occ    = rmu_pkg::count_t'(i) < eff_count;
			ctl_w[i].at_end = rmu_pkg::count_t'(i) == eff_count;
		end
		prev_gt_w[0]  = 1'b0;
		prev_val_w[0] = new_val;
		for (int i = 1; i < CAP; i++) begin
			prev_gt_w[i]  = gt_w[i-1];
			prev_val_w[i] = val_w[i-1];
		end
	end

	// The sorted insertion chain.
	for (genvar g = 0; g < CAP; g++) begin : g_chain
		rmu_cell u_stage (
			.clk      (clk),
			.ctl      (ctl_w[g]),
			.new_val  (new_val),
			.prev_val (prev_val_w[g]),
			.prev_gt  (prev_gt_w[g]),
			.val      (val_w[g]),
			.gt       (gt_w[g])
		);
	end

	// Sample count and the pending result flags.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			valid_s1 <= 1'b0;
			full_s1  <= 1'b0;
		end else begin
			if (in_take) begin
				valid_s1 <= 1'b1;
				full_s1  <= drop;
				if (!drop) begin
					count_q <= eff_count + rmu_pkg::count_t'(1);
				end
			end else if (s1_adv) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	// Lower median sits at index floor((count-1)/2); the count is never zero here.
	assign med_idx = rmu_pkg::IDX_W'((count_q - rmu_pkg::count_t'(1)) >> 1);

	always_comb begin
		med_val = '0;
		for (int i = 0; i < CAP; i++) begin
			med_val = med_val | (val_w[i] & {rmu_pkg::DATA_WIDTH{med_idx == rmu_pkg::index_t'(i)}});
		end
	end

	// Output register valid bit.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_adv) begin
			out_valid_q <= valid_s1;
		end
	end

	// Output register payload.
	always_ff @(posedge clk) begin
		if (s1_adv && valid_s1) begin
			median_q    <= rmu_pkg::SAMPLE_WIDTH'(med_val);
			count_out_q <= rmu_pkg::COUNT_PORT_WIDTH'(count_q);
			full_q      <= full_s1;
		end
	end

	assign out_valid    = out_valid_q;
	assign median       = median_q;
	assign stored_count = count_out_q;
	assign full_res     = full_q;

endmodule

[hdl/rmu_checker.sv]
`timescale 1ns / 1ps
// Port-level checks for the running median unit, bound to the top level.
// Depends on rmu_pkg and running_median_unit.
module rmu_checker (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   in_valid,
	input  logic                                   in_stall,
	input  logic signed [rmu_pkg::SAMPLE_WIDTH-1:0] sample,
	input  logic                                   start_req,
	input  logic                                   out_valid,
	input  logic                                   out_stall,
	input  logic signed [rmu_pkg::SAMPLE_WIDTH-1:0] median,
	input  logic [rmu_pkg::COUNT_PORT_WIDTH-1:0]    stored_count,
	input  logic                                   full_res
);

	localparam logic [rmu_pkg::COUNT_PORT_WIDTH-1:0] CAP_CNT =
		rmu_pkg::COUNT_PORT_WIDTH'(rmu_pkg::CAPACITY);

	// Every result reports at least one sample and no more than the capacity.
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (stored_count != '0) && (stored_count <= CAP_CNT))
		else $error("stored_count out of range");

	// A dropped sample is only reported with a full store.
	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && full_res) |-> (stored_count == CAP_CNT))
		else $error("full_res without a full store");

	// A stalled result stays and keeps its payload.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> out_valid && $stable(median)
			&& $stable(stored_count) && $stable(full_res))
		else $error("stalled result changed");

	// The input stalls only under output back-pressure.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (out_valid && out_stall))
		else $error("input stalled without output back-pressure");

	// A stalled input transaction stays offered with the same payload.
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_stall) |=> in_valid && $stable(sample) && $stable(start_req))
		else $error("stalled input transaction changed");

endmodule

bind running_median_unit rmu_checker u_rmu_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (in_valid),
	.in_stall     (in_stall),
	.sample       (sample),
	.start_req    (start_req),
	.out_valid    (out_valid),
	.out_stall    (out_stall),
	.median       (median),
	.stored_count (stored_count),
	.full_res     (full_res)
);

[bench/running_median_unit_tb.sv]
`timescale 1ns / 1ps
// Self-checking testbench for running_median_unit: sequences of signed samples
// against a sorted-list predictor of the lower median. Depends on rmu_pkg and the block's RTL.
module running_median_unit_tb;

	localparam int CLK_PERIOD = 10;
	localparam int RUN_ITEMS = 700;
	localparam int LIMIT_CYCLES = 200000;
	localparam int HOLD_CYCLES = 300;
	localparam int IDLE_PCT = 17;
	localparam int SETTLE_CYCLES = 8;
	localparam logic signed [rmu_pkg::SAMPLE_WIDTH-1:0] MIN_SAMPLE =
		{1'b1, {(rmu_pkg::SAMPLE_WIDTH-1){1'b0}}};
	localparam logic signed [rmu_pkg::SAMPLE_WIDTH-1:0] MAX_SAMPLE =
		{1'b0, {(rmu_pkg::SAMPLE_WIDTH-1){1'b1}}};

	// One result as the block should present it.
	typedef struct {
		logic signed [rmu_pkg::SAMPLE_WIDTH-1:0] median;
		logic [rmu_pkg::COUNT_PORT_WIDTH-1:0]    count;
		logic                                    full;
	} median_result_t;

	// Keeps its own sorted copy of the sequence and the results still owed.
	class median_tracker;
		rmu_pkg::data_t sorted_vals [rmu_pkg::CAPACITY];
		int             held;
		median_result_t awaited [$];
		int             mismatches;

		function new();
			held = 0;
			mismatches = 0;
		endfunction

		// Applies an accepted sample to the sorted copy and queues its result.
		function void note_sample(logic signed [rmu_pkg::SAMPLE_WIDTH-1:0] s,
				logic begin_seq);
			rmu_pkg::data_t v;
			int             pos;
			median_result_t r;
			v = rmu_pkg::data_t'(s);
			r.full = 1'b0;
			if (begin_seq)
				held = 0;
			if (held >= rmu_pkg::CAPACITY) begin
				r.full = 1'b1;
			end else begin
				// A new sample goes after any entries equal to it.
				pos = 0;
				while (pos < held && !(sorted_vals[pos] > v))
					pos++;
				for (int i = held; i > pos; i--)
					sorted_vals[i] = sorted_vals[i-1];
				sorted_vals[pos] = v;
				held++;
			end
			r.median = rmu_pkg::SAMPLE_WIDTH'(sorted_vals[(held - 1) / 2]);
			r.count = rmu_pkg::COUNT_PORT_WIDTH'(held);
			awaited = {awaited, r};
		endfunction

		task report_mismatch(string what);
			mismatches++;
			if (mismatches <= 40)
				$display("MISMATCH at %0t ns: %s", $time, what);
		endtask

		// Compares a delivered result with the oldest one owed.
		task check_result(logic signed [rmu_pkg::SAMPLE_WIDTH-1:0] med,
				logic [rmu_pkg::COUNT_PORT_WIDTH-1:0] cnt, logic full);
			median_result_t e;
			if (awaited.size() == 0) begin
				report_mismatch($sformatf("unexpected result: median %0d count %0d full %0b",
					med, cnt, full));
				return;
			end
			e = awaited.pop_front();
			if (med !== e.median)
				report_mismatch($sformatf("median %0d, expected %0d", med, e.median));
			if (cnt !== e.count)
				report_mismatch($sformatf("stored_count %0d, expected %0d", cnt, e.count));
			if (full !== e.full)
				report_mismatch($sformatf("full_res %0b, expected %0b", full, e.full));
		endtask
	endclass

	logic                                     clk = 1'b0;
	logic                                     arst_n = 1'b0;
	logic                                     in_valid = 1'b0;
	logic                                     in_stall;
	logic signed [rmu_pkg::SAMPLE_WIDTH-1:0]  sample = '0;
	logic                                     start_req = 1'b0;
	logic                                     out_valid;
	logic                                     out_stall = 1'b0;
	logic signed [rmu_pkg::SAMPLE_WIDTH-1:0]  median;
	logic [rmu_pkg::COUNT_PORT_WIDTH-1:0]     stored_count;
	logic                                     full_res;

	median_tracker tracker = new();
	int            items_sent = 0;
	int            cycle_count = 0;
	int            hold_requests = 0;
	int            hold_served = 0;
	int            hold_left = 0;
	bit            steady = 1'b0;

	running_median_unit DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.sample       (sample),
		.start_req    (start_req),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.median       (median),
		.stored_count (stored_count),
		.full_res     (full_res)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// Run limit.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= LIMIT_CYCLES) begin
			$display("running_median_unit_tb failed");
			$finish;
		end
	end

	// Result side: check each transaction taken, then choose the next stall.
	// A long hold-off is served here whenever the stimulus asks for one.
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			tracker.check_result(median, stored_count, full_res);
		if (hold_served != hold_requests) begin
			hold_served = hold_requests;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			out_stall <= 1'b1;
			hold_left--;
		end else begin
			out_stall <= !steady && ($urandom_range(0, 99) < IDLE_PCT);
		end
	end

	// Offers one sample, with random idle cycles ahead of it, and waits for acceptance.
	task automatic send_item(input logic signed [rmu_pkg::SAMPLE_WIDTH-1:0] s,
			input logic st);
		while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		sample <= s;
		start_req <= st;
		do @(posedge clk); while (in_stall);
		tracker.note_sample(s, st);
		items_sent++;
	endtask

	// Draws a sample: full range, a narrow band with many repeats, or near the extremes.
	function automatic logic signed [rmu_pkg::SAMPLE_WIDTH-1:0] pick_sample(int style);
		unique case (style)
			0: return $urandom;
			1: return int'($urandom_range(0, 16)) - 8;
			default: begin
				unique case ($urandom_range(0, 4))
					0: return MIN_SAMPLE + $urandom_range(0, 2);
					1: return MAX_SAMPLE - $urandom_range(0, 2);
					2: return -1;
					3: return '0;
					default: return $urandom;
				endcase
			end
		endcase
	endfunction

	// A sequence opens with start_req; a few stray starts break some sequences.
	task automatic send_sequence(int len, int style);
		for (int i = 0; i < len; i++)
			send_item(pick_sample(style), (i == 0) || ($urandom_range(0, 99) < 3));
	endtask

	// Stops offering until every owed result has been delivered.
	task automatic pause_until_drained();
		in_valid <= 1'b0;
		do @(posedge clk); while (tracker.awaited.size() != 0);
	endtask

	initial begin
		int  len;
		bit  hold_done;
		bit  drain_done;
		hold_done = 1'b0;
		drain_done = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: field extremes, repeated values and restarts.
		send_item('0, 1'b1);
		send_item(MAX_SAMPLE, 1'b0);
		send_item(MIN_SAMPLE, 1'b0);
		send_item(-1, 1'b0);
		send_item(-1, 1'b0);
		send_item(1, 1'b0);
		send_item(32'h5555_5555, 1'b0);
		send_item(32'hAAAA_AAAA, 1'b0);
		send_item(MIN_SAMPLE, 1'b1);
		send_item(MIN_SAMPLE, 1'b0);
		send_item(MAX_SAMPLE, 1'b0);
		send_item(MAX_SAMPLE, 1'b1);
		send_item(5, 1'b1);
		send_item(5, 1'b0);
		send_item(5, 1'b0);
		send_item(-5, 1'b0);
		send_item(3, 1'b0);
		send_item(7, 1'b0);

		// Overfill the store, then restart while it is full.
		send_sequence(rmu_pkg::CAPACITY + 6, 0);
		send_sequence(20, 1);

		// Random sequences, mostly short, some long enough to fill the store.
		while (items_sent < RUN_ITEMS) begin
			if (!hold_done && items_sent >= 150) begin
				hold_requests++;
				hold_done = 1'b1;
			end
			if (!drain_done && items_sent >= 350) begin
				pause_until_drained();
				drain_done = 1'b1;
			end
			steady = (items_sent >= 450) && (items_sent < 560);
			if ($urandom_range(0, 99) < 15)
				len = rmu_pkg::CAPACITY + $urandom_range(0, 8);
			else
				len = $urandom_range(1, 24);
			send_sequence(len, $urandom_range(0, 2));
		end
		steady = 1'b0;

		// Wait for the last results, then a little longer for anything stray.
		pause_until_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (tracker.mismatches == 0)
			$display("running_median_unit_tb passed");
		else
			$display("running_median_unit_tb failed");
		$finish;
	end

endmodule

[running_median_unit.f]
hdl/rmu_pkg.sv
hdl/rmu_cell.sv
hdl/running_median_unit.sv
hdl/rmu_checker.sv
bench/running_median_unit_tb.sv
